// ----- hdl/mbdp_pkg.sv -----
// Package for the multi-button debounce and press detect block.
// Holds field widths, reset values and the command word shared by the lanes.
// No dependencies.
`timescale 1ns / 1ps

package mbdp_pkg;

    localparam int LEVEL_W         = 8;
    localparam int TIME_W          = 32;
    localparam int DELAY_W         = 16;
    localparam int RESULT_W        = 4;
    localparam int BUTTONS_DEFAULT = 8;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = DELAY_W'(50);

    // Broadcast to every lane on each accepted sample word.
    typedef struct packed {
        logic               step;
        logic [TIME_W-1:0]  now_ms;
        logic [DELAY_W-1:0] debounce_ms;
    } lane_cmd_t;

endpackage

// ----- hdl/mbdp_lane.sv -----
// Debounce lane for one button: raw history, change timestamp, debounced level.
// Depends on mbdp_pkg.
`timescale 1ns / 1ps

module mbdp_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbdp_pkg::lane_cmd_t cmd,
    input  logic               raw,
    output logic               rose
);

    logic                        prev_reg, prev_next;
    logic                        stable_reg, stable_next;
    logic [mbdp_pkg::TIME_W-1:0] change_time_reg, change_time_next;

    logic                        raw_changed;
    logic [mbdp_pkg::TIME_W-1:0] elapsed;
    logic                        settled;
    logic                        update;

    always_comb begin
        raw_changed = (raw != prev_reg);
        // Modulo 2^32 elapsed time; a fresh change blocks settling outright,
        // so it never settles in the same sample.
        elapsed     = cmd.now_ms - change_time_reg;
        settled     = !raw_changed
                      && (elapsed > {{(mbdp_pkg::TIME_W-mbdp_pkg::DELAY_W){1'b0}},
                                     cmd.debounce_ms});
        update      = settled && (raw != stable_reg);
        rose        = cmd.step && update && raw;

        prev_next        = prev_reg;
        stable_next      = stable_reg;
        change_time_next = change_time_reg;
        if (cmd.step) begin
            prev_next = raw;
            if (raw_changed) begin
                change_time_next = cmd.now_ms;
            end
            if (update) begin
                stable_next = raw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg        <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
        end else begin
            prev_reg        <= prev_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

// ----- hdl/mbdp_merge.sv -----
// Merge stage: picks the highest rising lane and holds the result word.
// Depends on mbdp_pkg.
`timescale 1ns / 1ps

module mbdp_merge #(
    parameter int LANES = mbdp_pkg::BUTTONS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [LANES-1:0]              rose,
    output logic                          take_ok,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbdp_pkg::RESULT_W-1:0] m_pressed_button
);

    logic                          valid_reg, valid_next;
    logic [mbdp_pkg::RESULT_W-1:0] button_reg, button_next;
    logic [mbdp_pkg::RESULT_W-1:0] pick;

    // Highest index wins; 1-based, zero when nothing rose.
    always_comb begin
        pick = '0;
        for (int i = 0; i < LANES; i++) begin
            if (rose[i]) begin
                pick = mbdp_pkg::RESULT_W'(i + 1);
            end
        end
    end

    always_comb begin
        take_ok     = !valid_reg || m_ready;
        valid_next  = valid_reg;
        button_next = button_reg;
        if (step) begin
            valid_next  = 1'b1;
            button_next = pick;
        end else if (m_ready) begin
            valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        button_reg <= button_next;
    end

    assign m_valid          = valid_reg;
    assign m_pressed_button = button_reg;

endmodule

// ----- hdl/multi_button_debounce_press_detect_core.sv -----
// Top level of the multi-button debouncer with press detection.
// Depends on mbdp_pkg, mbdp_lane and mbdp_merge.
`timescale 1ns / 1ps

// Usage
//   Input channel (s_valid/s_ready): one word per sample, carrying the raw
//   button levels (bit i is button i) and the free-running millisecond time.
//   Result channel (m_valid/m_ready): one word per sample, the 1-based number
//   of the highest button whose debounced level rose in that sample, else 0.
//   Config channel (cfg_valid/cfg_ready): writes the debounce delay in ms; a
//   raw level must hold for strictly longer than this before it is taken.
//   Write it only while no sample is in flight. cfg_ready is always high.
// Timing
//   The result word is valid in the cycle after sample accept. Throughput is
//   one sample per cycle while the result register is free to load: every
//   button lane does its 32-bit elapsed-time subtract and compare in the
//   accept cycle, and the merge stage registers the priority-encoded result.
// Reset and stalls
//   Reset clears debounced levels, raw history and change times to zero and
//   restores the delay to 50 ms. While the receiver stalls, the result word
//   holds and s_ready stays high only if the result register is free to load.
//   Buttons at index 8 and above have no level bit, always read low and never
//   report, so only the lanes below that carry hardware.

module multi_button_debounce_press_detect_core #(
    parameter int BUTTONS = mbdp_pkg::BUTTONS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mbdp_pkg::LEVEL_W-1:0]  s_levels,
    input  logic [mbdp_pkg::TIME_W-1:0]   s_now_ms,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbdp_pkg::RESULT_W-1:0] m_pressed_button,
    // debounce delay writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbdp_pkg::DELAY_W-1:0]  cfg_debounce_ms
);

    // Lanes that can ever see a high level.
    localparam int LANES = (BUTTONS < mbdp_pkg::LEVEL_W) ? BUTTONS : mbdp_pkg::LEVEL_W;

    logic [mbdp_pkg::DELAY_W-1:0] debounce_reg, debounce_next;
    mbdp_pkg::lane_cmd_t          cmd;
    logic [LANES-1:0]             rose;
    logic                         take_ok;
    logic                         step;

    // Hold the delay; load it on every config write.
    assign cfg_ready = 1'b1;

    always_comb begin
        debounce_next = debounce_reg;
        if (cfg_valid && cfg_ready) begin
            debounce_next = cfg_debounce_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= mbdp_pkg::DEBOUNCE_RESET;
        end else begin
            debounce_reg <= debounce_next;
        end
    end

    // Advance all lanes together on each accepted sample word.
    assign s_ready = take_ok;
    assign step    = s_valid && take_ok;

    always_comb begin
        cmd.step        = step;
        cmd.now_ms      = s_now_ms;
        cmd.debounce_ms = debounce_reg;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mbdp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .raw     (s_levels[g]),
            .rose    (rose[g])
        );
    end

    // Combine the lane flags into one result word.
    mbdp_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .rose             (rose),
        .take_ok          (take_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed_button (m_pressed_button)
    );

endmodule

// ----- hdl/mbdp_checker.sv -----
// Port-level checks for the debounce core, bound to the top level.
// Depends on mbdp_pkg and multi_button_debounce_press_detect_core.
`timescale 1ns / 1ps

module mbdp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [mbdp_pkg::LEVEL_W-1:0]  s_levels,
    input logic [mbdp_pkg::TIME_W-1:0]   s_now_ms,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mbdp_pkg::RESULT_W-1:0] m_pressed_button,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [mbdp_pkg::DELAY_W-1:0]  cfg_debounce_ms
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted sample gave no result word next cycle");

    a_low_no_press: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_levels == '0) |=> (m_pressed_button == '0))
        else $error("press reported for an all-low sample");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pressed_button <= mbdp_pkg::RESULT_W'(mbdp_pkg::LEVEL_W)))
        else $error("button number out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressed_button))
        else $error("stalled result word changed");

endmodule

bind multi_button_debounce_press_detect_core mbdp_checker u_mbdp_checker (.*);

// ----- tb/tb_multi_button_debounce_press_detect_core.sv -----
// Self-checking testbench for multi_button_debounce_press_detect_core.
// Runs a directed table and then random debounce phases, and checks every result word.
// Depends on mbdp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_multi_button_debounce_press_detect_core;

    localparam int LEVEL_W         = mbdp_pkg::LEVEL_W;
    localparam int TIME_W          = mbdp_pkg::TIME_W;
    localparam int DELAY_W         = mbdp_pkg::DELAY_W;
    localparam int RESULT_W        = mbdp_pkg::RESULT_W;
    localparam int BUTTON_LANES    = mbdp_pkg::BUTTONS_DEFAULT;
    localparam int DIRECTED_ROWS   = 27;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum logic {ROW_SAMPLE, ROW_DELAY} row_kind_t;

    // One table row: a sample word, or a delay write carried in value[15:0].
    // Where typed is set, want is the press number written down by hand.
    typedef struct packed {
        row_kind_t           kind;
        logic [LEVEL_W-1:0]  levels;
        logic [TIME_W-1:0]   value;
        logic                typed;
        logic [RESULT_W-1:0] want;
    } plan_row_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [LEVEL_W-1:0]  s_levels        = '0;
    logic [TIME_W-1:0]   s_now_ms        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [RESULT_W-1:0] m_pressed_button;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [DELAY_W-1:0]  cfg_debounce_ms = '0;

    // Ride along with each sample word so the monitor knows how to check it.
    logic                row_typed = 1'b0;
    logic [RESULT_W-1:0] row_want  = '0;

    // Predictor state: delay, debounced levels, last raw levels, last change times.
    logic [DELAY_W-1:0]  hold_ms;
    logic [LEVEL_W-1:0]  settled;
    logic [LEVEL_W-1:0]  last_raw;
    logic [TIME_W-1:0]   change_stamp [BUTTON_LANES];

    logic [RESULT_W-1:0] pending_press [$];
    logic [RESULT_W-1:0] press_now;
    logic [RESULT_W-1:0] press_due;
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    bit                  gaps_on        = 1'b1;

    plan_row_t           directed_plan [DIRECTED_ROWS];

    multi_button_debounce_press_detect_core #(
        .BUTTONS(BUTTON_LANES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_levels        (s_levels),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed_button(m_pressed_button),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_debounce_ms (cfg_debounce_ms)
    );

    always #2 aclk = ~aclk;

    // Advance the debouncer by one sample and return the highest button that rose.
    // The elapsed time is a 32-bit difference, so it wraps like the free-running clock.
    function automatic logic [RESULT_W-1:0] debounce_sample(input logic [LEVEL_W-1:0] lv,
                                                            input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0]   elapsed;
        logic [RESULT_W-1:0] newest;
        newest = '0;
        for (int b = 0; b < BUTTON_LANES; b++) begin
            if (lv[b] != last_raw[b])
                change_stamp[b] = stamp;
            elapsed = stamp - change_stamp[b];
            if (elapsed > TIME_W'(hold_ms) && lv[b] != settled[b]) begin
                settled[b] = lv[b];
                if (lv[b])
                    newest = RESULT_W'(b + 1);
            end
        end
        last_raw = lv;
        return newest;
    endfunction

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Offer one sample word, with an optional idle burst in front; return at its accept edge.
    task automatic push_sample(input logic [LEVEL_W-1:0] lv, input logic [TIME_W-1:0] stamp,
                               input logic typed, input logic [RESULT_W-1:0] want);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_levels  <= lv;
        s_now_ms  <= stamp;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    // Hold off new samples until every expected result word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_press.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write the debounce delay, only once the block has gone idle.
    task automatic write_delay(input logic [DELAY_W-1:0] ms);
        drain_results();
        cfg_valid       <= 1'b1;
        cfg_debounce_ms <= ms;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Monitor: everything here uses values sampled at the edge. Update the delay on a
    // write, predict on an accepted sample, then check an accepted result word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_ms  = mbdp_pkg::DEBOUNCE_RESET;
            settled  = '0;
            last_raw = '0;
            foreach (change_stamp[b])
                change_stamp[b] = '0;
            idle_cycles = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                hold_ms = cfg_debounce_ms;
            if (s_valid && s_ready) begin
                press_now = debounce_sample(s_levels, s_now_ms);
                pending_press.push_back(row_typed ? row_want : press_now);
            end
            if (m_valid && m_ready) begin
                if (pending_press.size() == 0) begin
                    flag_mismatch($sformatf("result word %0d with no sample pending",
                                            m_pressed_button));
                end else begin
                    press_due = pending_press.pop_front();
                    if (m_pressed_button !== press_due)
                        flag_mismatch($sformatf("pressed_button %0d, expected %0d",
                                                m_pressed_button, press_due));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Receiver: drop ready for bursts while gaps are enabled, otherwise keep it high.
    initial begin
        forever begin
            @(posedge aclk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    initial begin
        @(posedge aclk);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("tb_multi_button_debounce_press_detect_core: FAIL");
        $finish;
    end

    initial begin
        logic [DELAY_W-1:0] phase_ms [RANDOM_PHASES];
        logic [TIME_W-1:0]  stamp;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] lv;
        int unsigned        span;
        int                 roll;

        // Reset-value delay (50 ms) first, then zero delay, then the longest delay.
        directed_plan = '{
            '{ROW_SAMPLE, 8'h00, 32'd0,        1'b1, 4'd0},  // reset state, nothing rises
            '{ROW_SAMPLE, 8'h01, 32'd10,       1'b1, 4'd0},  // button 1 goes high
            '{ROW_SAMPLE, 8'h01, 32'd60,       1'b1, 4'd0},  // held exactly the delay
            '{ROW_SAMPLE, 8'h01, 32'd61,       1'b1, 4'd1},  // one ms more: press
            '{ROW_SAMPLE, 8'h81, 32'd70,       1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h81, 32'd200,      1'b1, 4'd8},  // top button
            '{ROW_SAMPLE, 8'h00, 32'd210,      1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h00, 32'd300,      1'b1, 4'd0},  // releases are silent
            '{ROW_SAMPLE, 8'hFF, 32'd310,      1'b1, 4'd0},
            '{ROW_SAMPLE, 8'hFF, 32'd400,      1'b1, 4'd8},  // all rise, highest wins
            '{ROW_SAMPLE, 8'h7F, 32'd410,      1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h7F, 32'd500,      1'b1, 4'd0},
            '{ROW_SAMPLE, 8'hFF, 32'hFFFF_FFF0, 1'b1, 4'd0},
            '{ROW_SAMPLE, 8'hFF, 32'h0000_0030, 1'b1, 4'd8}, // press across the wrap
            '{ROW_SAMPLE, 8'h7F, 32'h0000_1000, 1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h7F, 32'h0000_0FFF, 1'b1, 4'd0}, // clock steps back
            '{ROW_DELAY,  8'h00, 32'd0,        1'b0, 4'd0},
            '{ROW_SAMPLE, 8'h00, 32'd1000,     1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h00, 32'd1001,     1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h10, 32'd1002,     1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h10, 32'd1002,     1'b1, 4'd0},  // no time passed yet
            '{ROW_SAMPLE, 8'h10, 32'd1003,     1'b1, 4'd5},  // zero delay, one ms later
            '{ROW_DELAY,  8'h00, 32'd65535,    1'b0, 4'd0},
            '{ROW_SAMPLE, 8'h00, 32'd2000,     1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h00, 32'd67535,    1'b1, 4'd0},
            '{ROW_SAMPLE, 8'h02, 32'd70000,    1'b0, 4'd0},
            '{ROW_SAMPLE, 8'h03, 32'hFFFF_FFFF, 1'b0, 4'd0}
        };

        // Hold reset, then release it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_DELAY)
                write_delay(directed_plan[r].value[DELAY_W-1:0]);
            else
                push_sample(directed_plan[r].levels, directed_plan[r].value,
                            directed_plan[r].typed, directed_plan[r].want);
        end

        // Random phases, each under its own delay. Extremes first, reset value last;
        // the last phase runs without random idle bursts on either side.
        phase_ms = '{16'd1, 16'd0, 16'hFFFF, DELAY_W'($urandom_range(2, 40)),
                     DELAY_W'($urandom_range(41, 300)), DELAY_W'($urandom_range(301, 5000)),
                     mbdp_pkg::DEBOUNCE_RESET};
        foreach (phase_ms[p]) begin
            write_delay(phase_ms[p]);
            gaps_on = (p != RANDOM_PHASES - 1);
            // Start two phases just below the wrap so the clock rolls over mid-phase.
            if (p == 0)
                stamp = 32'hFFFF_FF80;
            else if (p == 2)
                stamp = 32'hFFFF_0000;
            else
                stamp = $urandom();
            target = LEVEL_W'($urandom());
            span   = int'(phase_ms[p]) / 4 + 2;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Let the result side run dry once per phase.
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                // Mostly short steps so bounces stay inside the delay, some long ones
                // so levels settle, and a few jumps anywhere (backwards included).
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    stamp = $urandom();
                else if (roll < 75)
                    stamp = stamp + $urandom_range(0, span);
                else
                    stamp = stamp + $urandom_range(0, 8 * span);
                // Move the intended levels now and then; bounce single samples around them.
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    target = target ^ LEVEL_W'($urandom_range(1, 255));
                if (roll >= 12 && roll < 30)
                    lv = target ^ LEVEL_W'($urandom_range(1, 255));
                else
                    lv = target;
                push_sample(lv, stamp, 1'b0, '0);
            end
        end

        drain_results();
        if (pending_press.size() != 0)
            flag_mismatch($sformatf("%0d result words never came", pending_press.size()));

        if (mismatch_count == 0)
            $display("tb_multi_button_debounce_press_detect_core: PASS");
        else
            $display("tb_multi_button_debounce_press_detect_core: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mbdp_pkg.sv
hdl/mbdp_lane.sv
hdl/mbdp_merge.sv
hdl/multi_button_debounce_press_detect_core.sv
hdl/mbdp_checker.sv
tb/tb_multi_button_debounce_press_detect_core.sv
